// ===== rtl/core/perceptron_branch_predictor_core_defines.svh =====
// assertion macros used by the checker file
`ifndef PERCEPTRON_BRANCH_PREDICTOR_CORE_DEFINES_SVH
`define PERCEPTRON_BRANCH_PREDICTOR_CORE_DEFINES_SVH

// same-cycle implication
`define PBP_ASSERT_IMPL(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PBP_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pbp_pkg.sv =====
package pbp_pkg;

    localparam int PC_W  = 48;
    localparam int THR_W = 11;
    localparam int DOT_W = 13;

    localparam logic [THR_W-1:0] THR_RESET = 11'd45;

    localparam logic CMD_PREDICT = 1'b0;
    localparam logic CMD_UPDATE  = 1'b1;

    // two-bit code of one history slot
    typedef logic [1:0] t_hcode;
    localparam t_hcode H_EMPTY = 2'b00;
    localparam t_hcode H_POS   = 2'b01;
    localparam t_hcode H_NEG   = 2'b11;

endpackage

// ===== rtl/core/pbp_ram.sv =====
module pbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/pbp_index.sv =====
module pbp_index #(
    parameter int ENTRIES = 256,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [pbp_pkg::PC_W-1:0] i_pc,
    output logic                     o_done,
    output logic [IDX_W-1:0]         o_index
);

    logic             r_done;
    logic [IDX_W-1:0] r_index;

    assign o_done  = r_done;
    assign o_index = r_index;

    if (ENTRIES == 1) begin : g_single
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_done <= 1'b0;
            end else begin
                r_done <= i_start;
            end
            r_index <= '0;
        end
    end else if ((ENTRIES & (ENTRIES - 1)) == 0) begin : g_pow2
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_done <= 1'b0;
            end else begin
                r_done <= i_start;
            end
            if (i_start) begin
                r_index <= i_pc[IDX_W-1:0];
            end
        end
    end else begin : g_mod
        localparam int REM_W  = IDX_W + 1;
        localparam int FOLD_W = 27;
        localparam int PROD_W = 2 * FOLD_W;

        // byte weights 256^k mod ENTRIES and a reciprocal for the final reduction
        localparam logic [FOLD_W-1:0] E_VAL = FOLD_W'(ENTRIES);
        localparam logic [FOLD_W-1:0] R1    = FOLD_W'((64'd1 << 8) % ENTRIES);
        localparam logic [FOLD_W-1:0] R2    = FOLD_W'((64'd1 << 16) % ENTRIES);
        localparam logic [FOLD_W-1:0] R3    = FOLD_W'((64'd1 << 24) % ENTRIES);
        localparam logic [FOLD_W-1:0] R4    = FOLD_W'((64'd1 << 32) % ENTRIES);
        localparam logic [FOLD_W-1:0] R5    = FOLD_W'((64'd1 << 40) % ENTRIES);
        localparam logic [FOLD_W-1:0] RECIP = FOLD_W'((64'd1 << FOLD_W) / ENTRIES);

        logic              r_v1;
        logic              r_v2;
        logic              r_v3;
        logic [FOLD_W-1:0] r_fold;
        logic [FOLD_W-1:0] r_quot;
        logic [REM_W-1:0]  r_rem;
        logic [FOLD_W-1:0] fold;
        logic [PROD_W-1:0] prod;
        logic [FOLD_W-1:0] diff;

        // folded pc stays below 2^27, so the quotient estimate is low by at most one
        always_comb begin
            fold = FOLD_W'(i_pc[7:0])
                 + FOLD_W'(i_pc[15:8]) * R1
                 + FOLD_W'(i_pc[23:16]) * R2
                 + FOLD_W'(i_pc[31:24]) * R3
                 + FOLD_W'(i_pc[39:32]) * R4
                 + FOLD_W'(i_pc[47:40]) * R5;
            prod = PROD_W'(r_fold) * PROD_W'(RECIP);
            diff = r_fold - r_quot * E_VAL;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v1   <= 1'b0;
                r_v2   <= 1'b0;
                r_v3   <= 1'b0;
                r_done <= 1'b0;
            end else begin
                r_v1   <= i_start;
                r_v2   <= r_v1;
                r_v3   <= r_v2;
                r_done <= r_v3;
            end
            if (i_start) begin
                r_fold <= fold;
            end
            if (r_v1) begin
                r_quot <= prod[FOLD_W +: FOLD_W];
            end
            if (r_v2) begin
                r_rem <= diff[REM_W-1:0];
            end
            if (r_v3) begin
                if (r_rem >= REM_W'(ENTRIES)) begin
                    r_index <= IDX_W'(r_rem - REM_W'(ENTRIES));
                end else begin
                    r_index <= r_rem[IDX_W-1:0];
                end
            end
        end
    end

endmodule

// ===== rtl/core/perceptron_branch_predictor_core.sv =====
// channel | direction | handshake                 | payload
// in      | input     | i_in_valid / o_in_ready   | i_cmd i_pc i_taken i_guess
// out     | output    | o_out_valid / i_out_ready | o_prediction o_dot_sum o_trained
// cfg     | input     | i_cfg_we                  | i_cfg_data (train threshold)
//
// one word at a time; a predict runs through the accumulator one weight per cycle,
// an update reads the row and writes it back
// an index for ENTRIES not a power of two passes fold, quotient and remainder registers
// after reset a clearing pass zeroes every row of both memories, input ready low
// a result held by a stalled output blocks the next word only in its final S_DONE state
module perceptron_branch_predictor_core #(
    parameter int ENTRIES     = 256,
    parameter int HISTORY_LEN = 16,
    parameter int WEIGHT_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_cmd,
    input  logic [pbp_pkg::PC_W-1:0]          i_pc,
    input  logic                              i_taken,
    input  logic                              i_guess,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_prediction,
    output logic signed [pbp_pkg::DOT_W-1:0]  o_dot_sum,
    output logic                              o_trained,
    input  logic                              i_cfg_we,
    input  logic [pbp_pkg::THR_W-1:0]         i_cfg_data
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int W      = WEIGHT_BITS;
    localparam int ROW_W  = HISTORY_LEN * W;
    localparam int HIST_W = 2 * (HISTORY_LEN - 1);
    localparam int SLOT_W = $clog2(HISTORY_LEN);
    localparam int SUM_W  = W + $clog2(HISTORY_LEN) + 1;
    localparam int CMP_W  = (SUM_W > pbp_pkg::THR_W) ? SUM_W + 1 : pbp_pkg::THR_W + 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_INDEX = 3'd2;
    localparam logic [2:0] S_ACC   = 3'd3;
    localparam logic [2:0] S_TRAIN = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]                r_state;
    logic [IDX_W-1:0]          r_clr;
    logic [IDX_W-1:0]          r_idx;
    logic                      r_cmd;
    logic                      r_taken;
    logic                      r_guess;
    logic [SLOT_W-1:0]         r_slot;
    logic signed [SUM_W-1:0]   r_sum;
    logic signed [SUM_W-1:0]   r_last_sum;
    logic                      r_trained;
    logic [pbp_pkg::THR_W-1:0] r_thr;
    logic                      r_out_valid;
    logic                      r_out_pred;
    logic [pbp_pkg::DOT_W-1:0] r_out_dot;
    logic                      r_out_trained;

    logic                      in_acc;
    logic                      idx_done;
    logic [IDX_W-1:0]          idx_val;
    logic [ROW_W-1:0]          wt_rdata;
    logic [HIST_W-1:0]         hist_rdata;
    logic [2*HISTORY_LEN-1:0]  hist_full;
    logic                      mem_we_wt;
    logic                      mem_we_hist;
    logic [IDX_W-1:0]          mem_waddr;
    logic [ROW_W-1:0]          wt_wdata;
    logic [HIST_W-1:0]         hist_wdata;
    logic [ROW_W-1:0]          row_new;
    logic [HIST_W-1:0]         hist_new;
    logic signed [SUM_W-1:0]   term;
    logic signed [SUM_W-1:0]   n_sum;
    logic                      train_cond;
    logic                      out_load;
    pbp_pkg::t_hcode           tcode;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_prediction = r_out_pred;
    assign o_dot_sum   = r_out_dot;
    assign o_trained   = r_out_trained;

    pbp_index #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_index (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc),
        .i_pc    (i_pc),
        .o_done  (idx_done),
        .o_index (idx_val)
    );

    pbp_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ENTRIES),
        .AW    (IDX_W)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we_wt),
        .i_waddr (mem_waddr),
        .i_wdata (wt_wdata),
        .i_re    (idx_done),
        .i_raddr (idx_val),
        .o_rdata (wt_rdata)
    );

    pbp_ram #(
        .WIDTH (HIST_W),
        .DEPTH (ENTRIES),
        .AW    (IDX_W)
    ) u_history_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we_hist),
        .i_waddr (mem_waddr),
        .i_wdata (hist_wdata),
        .i_re    (idx_done),
        .i_raddr (idx_val),
        .o_rdata (hist_rdata)
    );

    // slot 0 always reads as +1
    assign hist_full = {hist_rdata, pbp_pkg::H_POS};
    assign tcode     = r_taken ? pbp_pkg::H_POS : pbp_pkg::H_NEG;

    // accumulate one weight per cycle
    always_comb begin
        logic signed [W-1:0]     w_sel;
        logic signed [SUM_W-1:0] w_ext;
        pbp_pkg::t_hcode         code;
        w_sel = wt_rdata[r_slot*W +: W];
        w_ext = SUM_W'(w_sel);
        code  = hist_full[r_slot*2 +: 2];
        case (code)
            pbp_pkg::H_POS: term = w_ext;
            pbp_pkg::H_NEG: term = -w_ext;
            default:        term = '0;
        endcase
        n_sum = r_sum + term;
    end

    // training row: each weight with a filled history slot moves by outcome times history, saturating
    always_comb begin
        logic signed [W-1:0] w_old;
        logic signed [W:0]   wide;
        pbp_pkg::t_hcode     code;
        logic                d_pos;
        logic                d_neg;
        row_new = '0;
        for (int i = 0; i < HISTORY_LEN; i++) begin
            w_old = wt_rdata[i*W +: W];
            code  = hist_full[i*2 +: 2];
            d_pos = (code == pbp_pkg::H_POS && r_taken) || (code == pbp_pkg::H_NEG && !r_taken);
            d_neg = (code == pbp_pkg::H_POS && !r_taken) || (code == pbp_pkg::H_NEG && r_taken);
            wide  = (W+1)'(w_old);
            if (d_pos) begin
                wide = wide + (W+1)'(1);
            end else if (d_neg) begin
                wide = wide - (W+1)'(1);
            end
            if (wide[W] != wide[W-1]) begin
                row_new[i*W +: W] = {wide[W], {(W-1){~wide[W]}}};
            end else begin
                row_new[i*W +: W] = wide[W-1:0];
            end
        end
    end

    // newest outcome enters the top slot, slot 1 drops out
    assign hist_new = (hist_rdata >> 2) | (HIST_W'(tcode) << (HIST_W - 2));

    assign train_cond = (r_guess != r_taken) ||
                        (signed'(CMP_W'(r_last_sum)) < signed'(CMP_W'(r_thr)));

    always_comb begin
        if (r_state == S_CLEAR) begin
            mem_we_wt   = 1'b1;
            mem_we_hist = 1'b1;
            mem_waddr   = r_clr;
            wt_wdata    = '0;
            hist_wdata  = '0;
        end else begin
            mem_we_wt   = (r_state == S_TRAIN) && train_cond;
            mem_we_hist = (r_state == S_TRAIN);
            mem_waddr   = r_idx;
            wt_wdata    = row_new;
            hist_wdata  = hist_new;
        end
    end

    assign out_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_last_sum  <= '0;
            r_thr       <= pbp_pkg::THR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + IDX_W'(1);
                    if (r_clr == IDX_W'(ENTRIES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_INDEX;
                    end
                end
                S_INDEX: begin
                    if (idx_done) begin
                        r_state <= (r_cmd == pbp_pkg::CMD_UPDATE) ? S_TRAIN : S_ACC;
                    end
                end
                S_ACC: begin
                    if (r_slot == SLOT_W'(HISTORY_LEN - 1)) begin
                        r_last_sum <= n_sum;
                        r_state    <= S_DONE;
                    end
                end
                S_TRAIN: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end

    // payload and datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd   <= i_cmd;
            r_taken <= i_taken;
            r_guess <= i_guess;
        end
        if (r_state == S_INDEX && idx_done) begin
            r_idx  <= idx_val;
            r_sum  <= SUM_W'(1);
            r_slot <= '0;
        end
        if (r_state == S_ACC) begin
            r_sum     <= n_sum;
            r_slot    <= r_slot + SLOT_W'(1);
            r_trained <= 1'b0;
        end
        if (r_state == S_TRAIN) begin
            r_trained <= train_cond;
        end
        if (out_load) begin
            r_out_pred    <= !r_last_sum[SUM_W-1];
            r_out_dot     <= (pbp_pkg::DOT_W)'(r_last_sum);
            r_out_trained <= r_trained;
        end
    end

endmodule

// ===== rtl/core/pbp_checker.sv =====
`include "perceptron_branch_predictor_core_defines.svh"

module pbp_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input logic                             o_prediction,
    input logic signed [pbp_pkg::DOT_W-1:0] o_dot_sum,
    input logic                             o_trained
);

    // a stalled result keeps its word
    `PBP_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_dot_sum) && $stable(o_prediction) && $stable(o_trained), "result changed while stalled")

    // one word in flight: ready drops right after an accept
    `PBP_ASSERT_NEXT(a_one_at_a_time, i_clk, !i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "input ready right after accept")

    // reset clears the output and starts the clearing pass
    `PBP_ASSERT_NEXT(a_reset_quiet, i_clk, 1'b0, !i_rst_n, !o_out_valid && !o_in_ready, "not quiet after reset")

    // a new result only appears after an earlier accepted word
    `PBP_ASSERT_NEXT(a_no_spurious, i_clk, !i_rst_n, !o_out_valid && o_in_ready, !o_out_valid, "result without input")

endmodule

bind perceptron_branch_predictor_core pbp_checker u_pbp_checker (.*);
